[rtl/pps_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_pkg
// shared widths, codes and types of the path point sampler
// ----------------------------------------------------------------------------
package pps_pkg;

  // coordinate and sample parameter formats
  localparam int COORD_BITS  = 24;
  localparam int T_FRAC_BITS = 16;

  // fixed field widths
  localparam int COUNT_BITS     = 12;
  localparam int TOTAL_BITS     = COUNT_BITS + 1;
  localparam int LIMIT_BITS     = 48;
  localparam int KIND_BITS      = 2;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = LIMIT_BITS;

  // distance path
  localparam int MAG_BITS  = COORD_BITS;
  localparam int SQ_BITS   = 2 * MAG_BITS;
  localparam int DIST_BITS = SQ_BITS + 1;
  localparam int CMP_BITS  = (DIST_BITS > LIMIT_BITS) ? DIST_BITS : LIMIT_BITS;

  // t = k / n, 0 .. 2^T_FRAC_BITS inclusive
  localparam int T_BITS     = T_FRAC_BITS + 1;
  localparam int DVD_BITS   = COUNT_BITS + T_BITS;
  localparam int DIV_STEP   = 4;
  localparam int DIV_STAGES = (T_BITS + DIV_STEP - 1) / DIV_STEP;
  localparam logic [T_BITS-1:0] T_ONE = {1'b1, {T_FRAC_BITS{1'b0}}};
  localparam int T_HALF = 1 << (T_FRAC_BITS - 1);

  // lerp product: (b - a) * t
  localparam int PROD_BITS = COORD_BITS + 1 + T_BITS + 1;

  // stream packing
  localparam int IN_FIELD_BITS  = 8 * COORD_BITS + COUNT_BITS;
  localparam int IN_TDATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int IN_TUSER_BITS  = KIND_BITS;
  localparam int OUT_FIELD_BITS = 2 * COORD_BITS + TOTAL_BITS;
  localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_TUSER_BITS = 1;

  // register reset values
  localparam logic [LIMIT_BITS-1:0] NEAR_LIMIT_RST = LIMIT_BITS'(6553600);   // 100 m^2
  localparam logic [LIMIT_BITS-1:0] FAR_LIMIT_RST  = LIMIT_BITS'(58982400);  // 900 m^2
  localparam logic [COUNT_BITS-1:0] NEAR_COUNT_RST = COUNT_BITS'(200);
  localparam logic [COUNT_BITS-1:0] MID_COUNT_RST  = COUNT_BITS'(500);
  localparam logic [COUNT_BITS-1:0] FAR_COUNT_RST  = COUNT_BITS'(1000);

  typedef enum logic [KIND_BITS-1:0] {
    KIND_FREE   = 2'd0,
    KIND_LINE   = 2'd1,
    KIND_BEZIER = 2'd2
  } kind_e;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_NEAR_LIMIT = 3'd0,
    CFG_FAR_LIMIT  = 3'd1,
    CFG_NEAR_COUNT = 3'd2,
    CFG_MID_COUNT  = 3'd3,
    CFG_FAR_COUNT  = 3'd4
  } cfg_index_e;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t sx;
    coord_t sy;
    coord_t fx;
    coord_t fy;
    coord_t c1x;
    coord_t c1y;
    coord_t c2x;
    coord_t c2y;
  } seg_t;

  typedef struct packed {
    logic [LIMIT_BITS-1:0] near_limit;
    logic [LIMIT_BITS-1:0] far_limit;
    logic [COUNT_BITS-1:0] near_count;
    logic [COUNT_BITS-1:0] mid_count;
    logic [COUNT_BITS-1:0] far_count;
  } cfg_t;

  typedef struct packed {
    logic                  line;
    logic                  active;
    logic                  in_range;
    logic                  last;
    logic [TOTAL_BITS-1:0] total;
  } meta_t;

endpackage

[rtl/pps_lerp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_lerp
// one rounded linear interpolation lane, product stage then sum stage
// ----------------------------------------------------------------------------
module pps_lerp (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  pps_pkg::coord_t                a_i,
  input  pps_pkg::coord_t                b_i,
  input  logic [pps_pkg::T_BITS-1:0]     t_i,
  output pps_pkg::coord_t                res_o
);
  import pps_pkg::*;

  logic signed [COORD_BITS:0]  diff;
  logic signed [PROD_BITS-1:0] prod_d, prod_q;
  logic signed [PROD_BITS-1:0] sum, scaled;
  coord_t                      a_q, res_d, res_q;

  assign diff   = $signed({b_i[COORD_BITS-1], b_i}) - $signed({a_i[COORD_BITS-1], a_i});
  assign prod_d = diff * $signed({1'b0, t_i});

  // floor of the rounded product, ties toward plus infinity
  assign sum    = prod_q + PROD_BITS'(T_HALF);
  assign scaled = sum >>> T_FRAC_BITS;
  assign res_d  = a_q + scaled[COORD_BITS-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      a_q    <= a_i;
      res_q  <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

[rtl/pps_count.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_count
// squared segment length, point count selection and divider setup
// ----------------------------------------------------------------------------
module pps_count (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  pps_pkg::seg_t                     seg_i,
  input  logic [pps_pkg::KIND_BITS-1:0]     kind_i,
  input  logic [pps_pkg::COUNT_BITS-1:0]    index_i,
  input  pps_pkg::cfg_t                     cfg_i,
  output logic                              valid_o,
  output pps_pkg::seg_t                     seg_o,
  output pps_pkg::meta_t                    meta_o,
  output logic [pps_pkg::COUNT_BITS-1:0]    count_o,
  output logic [pps_pkg::DVD_BITS-1:0]      dividend_o
);
  import pps_pkg::*;

  // stage 1: absolute differences
  logic signed [COORD_BITS:0] dx, dy;
  logic [MAG_BITS-1:0]        magx_d, magy_d, magx_q, magy_q;
  logic                       valid1_q;
  seg_t                       seg1_q;
  logic [KIND_BITS-1:0]       kind1_q;
  logic [COUNT_BITS-1:0]      idx1_q;

  // stage 2: squares
  logic [SQ_BITS-1:0]         sqx_d, sqy_d, sqx_q, sqy_q;
  logic                       valid2_q;
  seg_t                       seg2_q;
  logic [KIND_BITS-1:0]       kind2_q;
  logic [COUNT_BITS-1:0]      idx2_q;

  // stage 3: compare and select
  logic [DIST_BITS-1:0]       len_sq;
  logic                       is_near, is_mid;
  logic [COUNT_BITS-1:0]      n_sel, n_d, n3_q;
  logic                       valid3_q;
  seg_t                       seg3_q;
  logic [KIND_BITS-1:0]       kind3_q;
  logic [COUNT_BITS-1:0]      idx3_q;

  // stage 4: metadata and dividend
  meta_t                      meta_d, meta4_q;
  logic [DVD_BITS-1:0]        dvd_d, dvd4_q;
  logic                       valid4_q;
  seg_t                       seg4_q;
  logic [COUNT_BITS-1:0]      n4_q;

  assign dx     = $signed({seg_i.sx[COORD_BITS-1], seg_i.sx})
                - $signed({seg_i.fx[COORD_BITS-1], seg_i.fx});
  assign dy     = $signed({seg_i.sy[COORD_BITS-1], seg_i.sy})
                - $signed({seg_i.fy[COORD_BITS-1], seg_i.fy});
  assign magx_d = dx[COORD_BITS] ? MAG_BITS'(-dx) : MAG_BITS'(dx);
  assign magy_d = dy[COORD_BITS] ? MAG_BITS'(-dy) : MAG_BITS'(dy);

  assign sqx_d = magx_q * magx_q;
  assign sqy_d = magy_q * magy_q;

  assign len_sq  = DIST_BITS'(sqx_q) + DIST_BITS'(sqy_q);
  assign is_near = CMP_BITS'(len_sq) < CMP_BITS'(cfg_i.near_limit);
  assign is_mid  = CMP_BITS'(len_sq) < CMP_BITS'(cfg_i.far_limit);

  always_comb begin
    if (is_near) begin
      n_sel = cfg_i.near_count;
    end else if (is_mid) begin
      n_sel = cfg_i.mid_count;
    end else begin
      n_sel = cfg_i.far_count;
    end
    // a zero count behaves as one interval
    n_d = (n_sel == '0) ? COUNT_BITS'(1) : n_sel;
  end

  always_comb begin
    meta_d.line     = (kind_e'(kind3_q) == KIND_LINE);
    meta_d.active   = (kind_e'(kind3_q) == KIND_LINE) || (kind_e'(kind3_q) == KIND_BEZIER);
    meta_d.in_range = (idx3_q <= n3_q);
    meta_d.last     = (idx3_q == n3_q);
    meta_d.total    = meta_d.active ? (TOTAL_BITS'(n3_q) + TOTAL_BITS'(1)) : '0;
    // k * 2^F + floor(n / 2), rounds the quotient to nearest
    dvd_d = (DVD_BITS'(idx3_q) << T_FRAC_BITS) + DVD_BITS'(n3_q >> 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
      valid3_q <= 1'b0;
      valid4_q <= 1'b0;
    end else if (en_i) begin
      valid1_q <= valid_i;
      valid2_q <= valid1_q;
      valid3_q <= valid2_q;
      valid4_q <= valid3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      magx_q  <= magx_d;
      magy_q  <= magy_d;
      seg1_q  <= seg_i;
      kind1_q <= kind_i;
      idx1_q  <= index_i;

      sqx_q   <= sqx_d;
      sqy_q   <= sqy_d;
      seg2_q  <= seg1_q;
      kind2_q <= kind1_q;
      idx2_q  <= idx1_q;

      n3_q    <= n_d;
      seg3_q  <= seg2_q;
      kind3_q <= kind2_q;
      idx3_q  <= idx2_q;

      meta4_q <= meta_d;
      dvd4_q  <= dvd_d;
      seg4_q  <= seg3_q;
      n4_q    <= n3_q;
    end
  end

  assign valid_o    = valid4_q;
  assign seg_o      = seg4_q;
  assign meta_o     = meta4_q;
  assign count_o    = n4_q;
  assign dividend_o = dvd4_q;

endmodule

[rtl/pps_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_div
// pipelined restoring divider, t = dividend / n, a few quotient bits a stage
// ----------------------------------------------------------------------------
module pps_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  pps_pkg::seg_t                     seg_i,
  input  pps_pkg::meta_t                    meta_i,
  input  logic [pps_pkg::COUNT_BITS-1:0]    count_i,
  input  logic [pps_pkg::DVD_BITS-1:0]      dividend_i,
  output logic                              valid_o,
  output pps_pkg::seg_t                     seg_o,
  output pps_pkg::meta_t                    meta_o,
  output logic [pps_pkg::T_BITS-1:0]        t_o
);
  import pps_pkg::*;

  logic                  valid_q [DIV_STAGES];
  seg_t                  seg_q   [DIV_STAGES];
  meta_t                 meta_q  [DIV_STAGES];
  logic [COUNT_BITS-1:0] rem_q   [DIV_STAGES];
  logic [COUNT_BITS-1:0] cnt_q   [DIV_STAGES];
  logic [T_BITS-1:0]     low_q   [DIV_STAGES];
  logic [T_BITS-1:0]     quo_q   [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic                  valid_in;
    seg_t                  seg_in;
    meta_t                 meta_in;
    logic [COUNT_BITS-1:0] rem_in, cnt_in, rem_d;
    logic [T_BITS-1:0]     low_in, quo_in, low_d, quo_d;

    if (s == 0) begin : g_first
      // the top bits of the dividend start as the partial remainder
      assign valid_in = valid_i;
      assign seg_in   = seg_i;
      assign meta_in  = meta_i;
      assign rem_in   = dividend_i[T_BITS +: COUNT_BITS];
      assign cnt_in   = count_i;
      assign low_in   = dividend_i[T_BITS-1:0];
      assign quo_in   = '0;
    end else begin : g_next
      assign valid_in = valid_q[s-1];
      assign seg_in   = seg_q[s-1];
      assign meta_in  = meta_q[s-1];
      assign rem_in   = rem_q[s-1];
      assign cnt_in   = cnt_q[s-1];
      assign low_in   = low_q[s-1];
      assign quo_in   = quo_q[s-1];
    end

    always_comb begin
      logic [COUNT_BITS:0] trial;
      logic                qbit;
      rem_d = rem_in;
      low_d = low_in;
      quo_d = quo_in;
      trial = '0;
      qbit  = 1'b0;
      for (int j = 0; j < DIV_STEP; j++) begin
        if (s * DIV_STEP + j < T_BITS) begin
          trial = {rem_d, low_d[T_BITS-1]};
          qbit  = (trial >= {1'b0, cnt_in});
          rem_d = qbit ? COUNT_BITS'(trial - {1'b0, cnt_in}) : trial[COUNT_BITS-1:0];
          low_d = {low_d[T_BITS-2:0], 1'b0};
          quo_d = {quo_d[T_BITS-2:0], qbit};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (en_i) begin
        valid_q[s] <= valid_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        seg_q[s]  <= seg_in;
        meta_q[s] <= meta_in;
        rem_q[s]  <= rem_d;
        cnt_q[s]  <= cnt_in;
        low_q[s]  <= low_d;
        quo_q[s]  <= quo_d;
      end
    end
  end

  assign valid_o = valid_q[DIV_STAGES-1];
  assign seg_o   = seg_q[DIV_STAGES-1];
  assign meta_o  = meta_q[DIV_STAGES-1];
  assign t_o     = quo_q[DIV_STAGES-1];

  // an index within the path never gives t above one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && meta_o.in_range |-> t_o <= T_ONE)
    else $error("pps_div: t above one for an index within the path");

  // the final point sits exactly at t = 1
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && meta_o.last |-> t_o == T_ONE)
    else $error("pps_div: last point not at t = 1");

endmodule

[rtl/pps_bezier.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_bezier
// three de casteljau levels of lerp lanes per axis, line result carried along
// ----------------------------------------------------------------------------
module pps_bezier (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  pps_pkg::seg_t                 seg_i,
  input  pps_pkg::meta_t                meta_i,
  input  logic [pps_pkg::T_BITS-1:0]    t_i,
  output logic                          valid_o,
  output pps_pkg::meta_t                meta_o,
  output pps_pkg::coord_t               point_x_o,
  output pps_pkg::coord_t               point_y_o
);
  import pps_pkg::*;

  localparam int DEPTH = 6;

  logic              valid_q [DEPTH];
  meta_t             meta_q  [DEPTH];
  logic [T_BITS-1:0] t_q     [4];

  coord_t p0 [2];
  coord_t p1 [2];
  coord_t p2 [2];
  coord_t p3 [2];
  coord_t pt [2];

  assign p0[0] = seg_i.sx;
  assign p0[1] = seg_i.sy;
  assign p1[0] = seg_i.c1x;
  assign p1[1] = seg_i.c1y;
  assign p2[0] = seg_i.c2x;
  assign p2[1] = seg_i.c2y;
  assign p3[0] = seg_i.fx;
  assign p3[1] = seg_i.fy;

  for (genvar ax = 0; ax < 2; ax++) begin : g_axis
    coord_t b0;
    coord_t r1 [3];
    coord_t r2 [2];
    coord_t r3;
    coord_t line_q [4];

    // a straight path runs start to finish in the first lane
    assign b0 = meta_i.line ? p3[ax] : p1[ax];

    pps_lerp u_l1_0 (.clk_i, .en_i, .a_i(p0[ax]), .b_i(b0),     .t_i(t_i), .res_o(r1[0]));
    pps_lerp u_l1_1 (.clk_i, .en_i, .a_i(p1[ax]), .b_i(p2[ax]), .t_i(t_i), .res_o(r1[1]));
    pps_lerp u_l1_2 (.clk_i, .en_i, .a_i(p2[ax]), .b_i(p3[ax]), .t_i(t_i), .res_o(r1[2]));

    pps_lerp u_l2_0 (.clk_i, .en_i, .a_i(r1[0]), .b_i(r1[1]), .t_i(t_q[1]), .res_o(r2[0]));
    pps_lerp u_l2_1 (.clk_i, .en_i, .a_i(r1[1]), .b_i(r1[2]), .t_i(t_q[1]), .res_o(r2[1]));

    pps_lerp u_l3 (.clk_i, .en_i, .a_i(r2[0]), .b_i(r2[1]), .t_i(t_q[3]), .res_o(r3));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        line_q[0] <= r1[0];
        for (int i = 1; i < 4; i++) begin
          line_q[i] <= line_q[i-1];
        end
      end
    end

    assign pt[ax] = meta_q[DEPTH-1].line ? line_q[3] : r3;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) begin
        valid_q[i] <= 1'b0;
      end
    end else if (en_i) begin
      valid_q[0] <= valid_i;
      for (int i = 1; i < DEPTH; i++) begin
        valid_q[i] <= valid_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      meta_q[0] <= meta_i;
      for (int i = 1; i < DEPTH; i++) begin
        meta_q[i] <= meta_q[i-1];
      end
      t_q[0] <= t_i;
      for (int i = 1; i < 4; i++) begin
        t_q[i] <= t_q[i-1];
      end
    end
  end

  assign valid_o   = valid_q[DEPTH-1];
  assign meta_o    = meta_q[DEPTH-1];
  assign point_x_o = pt[0];
  assign point_y_o = pt[1];

endmodule

[rtl/path_point_sampler.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// path_point_sampler
// one point of a straight or cubic bezier path segment per request
// ----------------------------------------------------------------------------
// Each request names a segment (start, finish, two control points, a kind)
// and a sample index k. The squared start-to-finish length picks the interval
// count n from the near, mid and far count registers; the point at t = k/n is
// returned in signed Q15.8, rounded after every interpolation. A free kind
// gives an all-zero point with a zero total; an index beyond n gives a zero
// point that still reports n+1 as the total. The block takes one request per
// cycle while the output is not stalled and returns one point for every
// request, through 4 length/count stages, 5 divider stages for t, 6
// interpolation stages and the output register. The whole pipeline holds
// while a finished point waits on the output, so input readiness follows the
// output side in the same cycle. The user must write registers only while
// no request is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module path_point_sampler (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,

  // configuration write channel
  input  logic                                    cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  logic [pps_pkg::CFG_INDEX_BITS-1:0]      cfg_index_i,
  input  logic [pps_pkg::CFG_DATA_BITS-1:0]       cfg_data_i,

  // segment requests
  input  logic                                    s_axis_tvalid,
  output logic                                    s_axis_tready,
  // start_x, start_y, finish_x, finish_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y,
  // sample_index, zero pad
  input  logic [pps_pkg::IN_TDATA_BITS-1:0]       s_axis_tdata,
  // path_kind
  input  logic [pps_pkg::IN_TUSER_BITS-1:0]       s_axis_tuser,

  // sampled points
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  // point_x, point_y, point_total, zero pad
  output logic [pps_pkg::OUT_TDATA_BITS-1:0]      m_axis_tdata,
  // point_valid
  output logic [pps_pkg::OUT_TUSER_BITS-1:0]      m_axis_tuser,
  // last_point
  output logic                                    m_axis_tlast
);
  import pps_pkg::*;

  // configuration registers
  cfg_t cfg_q;

  // pipeline advance: everything moves unless the output holds a point not taken
  logic en;

  // request unpacking
  seg_t                  seg_in;
  logic [COUNT_BITS-1:0] index_in;

  // count stages to divider
  logic                  cnt_valid;
  seg_t                  cnt_seg;
  meta_t                 cnt_meta;
  logic [COUNT_BITS-1:0] cnt_n;
  logic [DVD_BITS-1:0]   cnt_dvd;

  // divider to interpolation
  logic                  div_valid;
  seg_t                  div_seg;
  meta_t                 div_meta;
  logic [T_BITS-1:0]     div_t;

  // interpolation to output
  logic                  bez_valid;
  meta_t                 bez_meta;
  coord_t                bez_x, bez_y;
  logic                  point_ok;

  // output register
  logic                  out_valid_q;
  coord_t                out_x_d, out_x_q, out_y_d, out_y_q;
  logic                  out_ok_q, out_last_d, out_last_q;
  logic [TOTAL_BITS-1:0] out_total_q;

  // --------------------------------------------------------------------------
  // configuration, always ready
  // --------------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.near_limit <= NEAR_LIMIT_RST;
      cfg_q.far_limit  <= FAR_LIMIT_RST;
      cfg_q.near_count <= NEAR_COUNT_RST;
      cfg_q.mid_count  <= MID_COUNT_RST;
      cfg_q.far_count  <= FAR_COUNT_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_NEAR_LIMIT: cfg_q.near_limit <= cfg_data_i[LIMIT_BITS-1:0];
        CFG_FAR_LIMIT:  cfg_q.far_limit  <= cfg_data_i[LIMIT_BITS-1:0];
        CFG_NEAR_COUNT: cfg_q.near_count <= cfg_data_i[COUNT_BITS-1:0];
        CFG_MID_COUNT:  cfg_q.mid_count  <= cfg_data_i[COUNT_BITS-1:0];
        CFG_FAR_COUNT:  cfg_q.far_count  <= cfg_data_i[COUNT_BITS-1:0];
        default: ;  // writes past the register list are dropped
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // request side
  // --------------------------------------------------------------------------
  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  assign seg_in.sx  = s_axis_tdata[0*COORD_BITS +: COORD_BITS];
  assign seg_in.sy  = s_axis_tdata[1*COORD_BITS +: COORD_BITS];
  assign seg_in.fx  = s_axis_tdata[2*COORD_BITS +: COORD_BITS];
  assign seg_in.fy  = s_axis_tdata[3*COORD_BITS +: COORD_BITS];
  assign seg_in.c1x = s_axis_tdata[4*COORD_BITS +: COORD_BITS];
  assign seg_in.c1y = s_axis_tdata[5*COORD_BITS +: COORD_BITS];
  assign seg_in.c2x = s_axis_tdata[6*COORD_BITS +: COORD_BITS];
  assign seg_in.c2y = s_axis_tdata[7*COORD_BITS +: COORD_BITS];
  assign index_in   = s_axis_tdata[8*COORD_BITS +: COUNT_BITS];

  // length, count choice and dividend
  pps_count u_count (
    .clk_i,
    .rst_ni,
    .en_i       (en),
    .valid_i    (s_axis_tvalid),
    .seg_i      (seg_in),
    .kind_i     (s_axis_tuser[KIND_BITS-1:0]),
    .index_i    (index_in),
    .cfg_i      (cfg_q),
    .valid_o    (cnt_valid),
    .seg_o      (cnt_seg),
    .meta_o     (cnt_meta),
    .count_o    (cnt_n),
    .dividend_o (cnt_dvd)
  );

  // t = round(k / n) in T_FRAC_BITS fraction bits
  pps_div u_div (
    .clk_i,
    .rst_ni,
    .en_i       (en),
    .valid_i    (cnt_valid),
    .seg_i      (cnt_seg),
    .meta_i     (cnt_meta),
    .count_i    (cnt_n),
    .dividend_i (cnt_dvd),
    .valid_o    (div_valid),
    .seg_o      (div_seg),
    .meta_o     (div_meta),
    .t_o        (div_t)
  );

  // straight or de casteljau evaluation
  pps_bezier u_bezier (
    .clk_i,
    .rst_ni,
    .en_i      (en),
    .valid_i   (div_valid),
    .seg_i     (div_seg),
    .meta_i    (div_meta),
    .t_i       (div_t),
    .valid_o   (bez_valid),
    .meta_o    (bez_meta),
    .point_x_o (bez_x),
    .point_y_o (bez_y)
  );

  // --------------------------------------------------------------------------
  // output register: free kinds and out-of-range indices read as zero points
  // --------------------------------------------------------------------------
  assign point_ok   = bez_meta.active && bez_meta.in_range;
  assign out_x_d    = point_ok ? bez_x : '0;
  assign out_y_d    = point_ok ? bez_y : '0;
  assign out_last_d = point_ok && bez_meta.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= bez_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_x_q     <= out_x_d;
      out_y_q     <= out_y_d;
      out_ok_q    <= point_ok;
      out_last_q  <= out_last_d;
      out_total_q <= bez_meta.total;
    end
  end

  always_comb begin
    m_axis_tdata = '0;
    m_axis_tdata[0 +: COORD_BITS]          = out_x_q;
    m_axis_tdata[COORD_BITS +: COORD_BITS] = out_y_q;
    m_axis_tdata[2*COORD_BITS +: TOTAL_BITS] = out_total_q;
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tuser[0] = out_ok_q;
  assign m_axis_tlast    = out_last_q;

  // --------------------------------------------------------------------------
  // checks
  // --------------------------------------------------------------------------

  // a point that is not on the path carries no coordinates and no last flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |->
      out_x_q == '0 && out_y_q == '0 && !m_axis_tlast)
    else $error("path_point_sampler: stray data on an empty point");

  // a point on the path belongs to a path of at least two points
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> out_total_q >= TOTAL_BITS'(2))
    else $error("path_point_sampler: point total too small for a valid point");

  // the final point is always a valid point
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[0])
    else $error("path_point_sampler: last flag on an invalid point");

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the path point sampler
// ----------------------------------------------------------------------------
// A short table of hand-picked segment requests runs first. It covers the
// coordinate extremes, every path kind, exact threshold edges, the first and
// last sample and indexes past the last sample. After it come random phases,
// each under its own register setting: reset values, all-zero limits and
// counts, all-ones limits and counts, thresholds out of order, then random
// settings. Every accepted request without a hand-typed answer is predicted
// by a fixed-point model held in this bench. Returned points are compared
// with the predictions in order. The sender works in bursts with gaps, and
// the receiver stalls on a changing pattern.
// ----------------------------------------------------------------------------
module tb_top;
  import pps_pkg::*;

  localparam int          PIPE_LATENCY    = 16;
  localparam int          RANDOM_PHASES   = 8;
  localparam int          ITEMS_PER_PHASE = 167;
  localparam int          DRAIN_LIMIT     = 20000;
  localparam int          METRE           = 256;   // one metre in Q15.8
  localparam longint      TIMEOUT_NS      = 10_000_000;

  // kind 3 has no enum member; the block treats it as free
  localparam logic [KIND_BITS-1:0]      KIND_SPARE      = 2'd3;
  // an index past the register list, must be ignored
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_INDEX = 3'd7;

  localparam coord_t                    COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam coord_t                    COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic [LIMIT_BITS-1:0]     LIMIT_MAX = '1;
  localparam logic [COUNT_BITS-1:0]     COUNT_MAX = '1;

  // one sampled point as the block returns it
  typedef struct packed {
    coord_t                px;
    coord_t                py;
    logic                  valid;
    logic                  last;
    logic [TOTAL_BITS-1:0] total;
  } point_t;

  // one row of the hand-written request table
  typedef struct {
    seg_t                  seg;
    logic [KIND_BITS-1:0]  kind;
    logic [COUNT_BITS-1:0] k;
    bit                    typed;   // want holds the hand-typed answer
    point_t                want;
  } row_t;

  typedef enum int unsigned {
    RX_STREAM,   // always ready
    RX_COIN,     // ready on a coin toss
    RX_COMB,     // ready while the timer modulo eight is below five
    RX_CHOKE     // ready with a chance of one in eight
  } rx_mode_e;

  logic                       clk_i         = 1'b0;
  logic                       rst_ni        = 1'b0;
  logic                       cfg_valid_i   = 1'b0;
  logic                       cfg_ready_o;
  logic [CFG_INDEX_BITS-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_BITS-1:0]   cfg_data_i    = '0;
  logic                       s_axis_tvalid = 1'b0;
  logic                       s_axis_tready;
  logic [IN_TDATA_BITS-1:0]   s_axis_tdata  = '0;
  logic [IN_TUSER_BITS-1:0]   s_axis_tuser  = '0;
  logic                       m_axis_tvalid;
  logic                       m_axis_tready = 1'b1;
  logic [OUT_TDATA_BITS-1:0]  m_axis_tdata;
  logic [OUT_TUSER_BITS-1:0]  m_axis_tuser;
  logic                       m_axis_tlast;

  // register values the block should hold right now
  cfg_t active_setting = '{near_limit: NEAR_LIMIT_RST, far_limit: FAR_LIMIT_RST,
                           near_count: NEAR_COUNT_RST, mid_count: MID_COUNT_RST,
                           far_count: FAR_COUNT_RST};

  point_t      expected_points[$];
  row_t        directed_rows[$];

  int unsigned mismatches      = 0;
  int unsigned requests_sent   = 0;
  int unsigned points_checked  = 0;
  int unsigned points_in_range = 0;
  int unsigned points_beyond   = 0;
  int unsigned points_free     = 0;
  int unsigned settings_used   = 1;

  // sender burst pacing
  int unsigned burst_left = 0;
  bit          steady     = 1'b0;

  // receiver stall pattern
  rx_mode_e    rx_mode    = RX_STREAM;
  int unsigned rx_timer   = 0;

  path_point_sampler DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #10 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // fixed-point point predictor
  // ---------------------------------------------------------------------------

  // a + (b - a) * t, rounded to nearest with ties toward plus infinity;
  // the arithmetic shift floors negative sums as well
  function automatic longint blend(longint a, longint b, longint t);
    longint w;
    w = a * ((longint'(1) << T_FRAC_BITS) - t) + b * t + (longint'(1) << (T_FRAC_BITS - 1));
    return w >>> T_FRAC_BITS;
  endfunction

  // de casteljau on one axis, every stage rounded back to a coordinate
  function automatic longint cubic_axis(longint p0, longint p1, longint p2, longint p3,
                                        longint t);
    longint a, b, c, d, e;
    a = blend(p0, p1, t);
    b = blend(p1, p2, t);
    c = blend(p2, p3, t);
    d = blend(a, b, t);
    e = blend(b, c, t);
    return blend(d, e, t);
  endfunction

  // interval count picked by the squared start-to-finish length
  function automatic int unsigned interval_count(seg_t s);
    longint          dx, dy;
    longint unsigned span_sq;
    int unsigned     n;
    dx = longint'($signed(s.sx)) - longint'($signed(s.fx));
    dy = longint'($signed(s.sy)) - longint'($signed(s.fy));
    span_sq = dx * dx + dy * dy;
    // near test first, even when the limits are out of order
    if (span_sq < active_setting.near_limit)
      n = active_setting.near_count;
    else if (span_sq < active_setting.far_limit)
      n = active_setting.mid_count;
    else
      n = active_setting.far_count;
    if (n == 0)
      n = 1;
    return n;
  endfunction

  function automatic point_t sample_point(seg_t s, logic [KIND_BITS-1:0] kind,
                                          int unsigned k);
    point_t      p;
    int unsigned n;
    longint      t;
    p = '0;
    if (kind != KIND_LINE && kind != KIND_BEZIER)
      return p;
    n = interval_count(s);
    p.total = TOTAL_BITS'(n + 1);
    if (k > n)
      return p;
    // t = k/n rounded to nearest with ties up, in integer arithmetic
    t = ((longint'(k) << T_FRAC_BITS) + longint'(n / 2)) / longint'(n);
    if (kind == KIND_LINE) begin
      p.px = coord_t'(blend($signed(s.sx), $signed(s.fx), t));
      p.py = coord_t'(blend($signed(s.sy), $signed(s.fy), t));
    end else begin
      p.px = coord_t'(cubic_axis($signed(s.sx), $signed(s.c1x), $signed(s.c2x),
                                 $signed(s.fx), t));
      p.py = coord_t'(cubic_axis($signed(s.sy), $signed(s.c1y), $signed(s.c2y),
                                 $signed(s.fy), t));
    end
    p.valid = 1'b1;
    p.last  = (k == n);
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // table helpers
  // ---------------------------------------------------------------------------

  function automatic seg_t mk_seg(coord_t sx, coord_t sy, coord_t fx, coord_t fy,
                                  coord_t c1x, coord_t c1y, coord_t c2x, coord_t c2y);
    seg_t s;
    s.sx  = sx;
    s.sy  = sy;
    s.fx  = fx;
    s.fy  = fy;
    s.c1x = c1x;
    s.c1y = c1y;
    s.c2x = c2x;
    s.c2y = c2y;
    return s;
  endfunction

  function automatic point_t mk_point(coord_t x, coord_t y, bit v, bit l,
                                      int unsigned total);
    point_t p;
    p.px    = x;
    p.py    = y;
    p.valid = v;
    p.last  = l;
    p.total = TOTAL_BITS'(total);
    return p;
  endfunction

  task automatic add_row(seg_t s, logic [KIND_BITS-1:0] kind, int unsigned k, bit typed,
                         point_t want);
    row_t r;
    r.seg   = s;
    r.kind  = kind;
    r.k     = COUNT_BITS'(k);
    r.typed = typed;
    r.want  = want;
    directed_rows = {directed_rows, r};
  endtask

  // ---------------------------------------------------------------------------
  // driving
  // ---------------------------------------------------------------------------

  // present one segment request and hold it until the block takes it
  task automatic send_segment(seg_t s, logic [KIND_BITS-1:0] kind,
                              logic [COUNT_BITS-1:0] k, bit typed, point_t typed_want);
    point_t want;
    s_axis_tvalid <= 1'b1;
    // start_x lowest, then start_y, finish, ctrl1, ctrl2, sample_index
    s_axis_tdata  <= IN_TDATA_BITS'({k, s.c2y, s.c2x, s.c1y, s.c1x,
                                     s.fy, s.fx, s.sy, s.sx});
    s_axis_tuser  <= kind;
    @(posedge clk_i);
    while (!s_axis_tready)
      @(posedge clk_i);
    want = typed ? typed_want : sample_point(s, kind, k);
    expected_points = {expected_points, want};
    requests_sent++;
  endtask

  // burst pacing: after a burst runs out, maybe leave a gap
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap        = (steady || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // stop sending and let every outstanding point come back
  task automatic settle_block();
    s_axis_tvalid <= 1'b0;
    while (expected_points.size() != 0)
      @(posedge clk_i);
    repeat (PIPE_LATENCY) @(posedge clk_i);
  endtask

  task automatic write_register(logic [CFG_INDEX_BITS-1:0] index,
                                logic [CFG_DATA_BITS-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o)
      @(posedge clk_i);
    case (index)
      CFG_NEAR_LIMIT: active_setting.near_limit = value[LIMIT_BITS-1:0];
      CFG_FAR_LIMIT:  active_setting.far_limit  = value[LIMIT_BITS-1:0];
      CFG_NEAR_COUNT: active_setting.near_count = value[COUNT_BITS-1:0];
      CFG_MID_COUNT:  active_setting.mid_count  = value[COUNT_BITS-1:0];
      CFG_FAR_COUNT:  active_setting.far_count  = value[COUNT_BITS-1:0];
      default: ;
    endcase
  endtask

  // writes every register, plus an out-of-range index now and then
  task automatic load_setting(cfg_t c, bit with_spare);
    write_register(CFG_NEAR_LIMIT, CFG_DATA_BITS'(c.near_limit));
    write_register(CFG_FAR_LIMIT,  CFG_DATA_BITS'(c.far_limit));
    write_register(CFG_NEAR_COUNT, CFG_DATA_BITS'(c.near_count));
    write_register(CFG_MID_COUNT,  CFG_DATA_BITS'(c.mid_count));
    write_register(CFG_FAR_COUNT,  CFG_DATA_BITS'(c.far_count));
    if (with_spare)
      write_register(CFG_SPARE_INDEX, CFG_DATA_BITS'({$urandom, $urandom}));
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  // ---------------------------------------------------------------------------
  // receiver stall pattern, switches mode when a random timer runs out
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rx_timer == 0) begin
      rx_mode  <= rx_mode_e'($urandom_range(0, 3));
      rx_timer <= $urandom_range(20, 200);
    end else begin
      rx_timer <= rx_timer - 1;
    end
    case (rx_mode)
      RX_STREAM: m_axis_tready <= 1'b1;
      RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
      RX_COMB:   m_axis_tready <= (rx_timer % 8) < 5;
      default:   m_axis_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatches++;
    $display("%0t: mismatch on %s at point %0d: got %0h, want %0h",
             $time, what, points_checked, got, want);
  endtask

  always @(posedge clk_i) begin : point_checker
    point_t                want;
    coord_t                got_x, got_y;
    logic [TOTAL_BITS-1:0] got_total;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_x     = m_axis_tdata[COORD_BITS-1:0];
      got_y     = m_axis_tdata[2*COORD_BITS-1:COORD_BITS];
      got_total = m_axis_tdata[2*COORD_BITS+TOTAL_BITS-1:2*COORD_BITS];
      if (expected_points.size() == 0) begin
        report_mismatch("point with no request pending", 64'(got_total), 64'(0));
      end else begin
        want = expected_points.pop_front();
        if (got_x !== want.px)
          report_mismatch("point_x", 64'(got_x), 64'(want.px));
        if (got_y !== want.py)
          report_mismatch("point_y", 64'(got_y), 64'(want.py));
        if (m_axis_tuser[0] !== want.valid)
          report_mismatch("point_valid", 64'(m_axis_tuser[0]), 64'(want.valid));
        if (m_axis_tlast !== want.last)
          report_mismatch("last_point", 64'(m_axis_tlast), 64'(want.last));
        if (got_total !== want.total)
          report_mismatch("point_total", 64'(got_total), 64'(want.total));
        if (want.valid)
          points_in_range++;
        else if (want.total != 0)
          points_beyond++;
        else
          points_free++;
      end
      points_checked++;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    seg_t                  seg_a, seg_b, seg_wide, seg_knot, s;
    cfg_t                  setting;
    logic [KIND_BITS-1:0]  kind;
    int unsigned           n, k, pick, sh, waited;

    // short segment (n = 200 at reset): line and bezier share the ends
    seg_a    = mk_seg(-3*METRE, 2*METRE, 2*METRE, -2*METRE,
                      COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX);
    seg_b    = mk_seg(-3*METRE, 2*METRE, 2*METRE, -2*METRE,
                      COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN);
    // corner to corner, always the far count
    seg_wide = mk_seg(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
                      COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX);
    seg_knot = mk_seg(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX,
                      COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);

    // free kinds give an all-zero point
    add_row(seg_wide, KIND_FREE,  0,    1, '0);
    add_row(seg_a,    KIND_SPARE, 4095, 1, '0);
    // straight line: ends exact, past the end zero with the total kept
    add_row(seg_a, KIND_LINE, 0,    1, mk_point(-3*METRE, 2*METRE, 1, 0, 201));
    add_row(seg_a, KIND_LINE, 200,  1, mk_point(2*METRE, -2*METRE, 1, 1, 201));
    add_row(seg_a, KIND_LINE, 201,  1, mk_point(0, 0, 0, 0, 201));
    add_row(seg_a, KIND_LINE, 4095, 1, mk_point(0, 0, 0, 0, 201));
    add_row(seg_a, KIND_LINE, 1,    0, '0);
    add_row(seg_a, KIND_LINE, 100,  0, '0);
    // bezier ends land on start and finish whatever the control points
    add_row(seg_b, KIND_BEZIER, 0,   1, mk_point(-3*METRE, 2*METRE, 1, 0, 201));
    add_row(seg_b, KIND_BEZIER, 200, 1, mk_point(2*METRE, -2*METRE, 1, 1, 201));
    add_row(seg_b, KIND_BEZIER, 37,  0, '0);
    add_row(seg_b, KIND_BEZIER, 199, 0, '0);
    add_row(seg_b, KIND_BEZIER, 201, 1, mk_point(0, 0, 0, 0, 201));
    // threshold edges: a length equal to a limit falls in the next band
    add_row(mk_seg(0, 0, 10*METRE, 0, 0, 0, 0, 0), KIND_LINE, 500, 1,
            mk_point(10*METRE, 0, 1, 1, 501));
    add_row(mk_seg(0, 0, 10*METRE-1, 0, 0, 0, 0, 0), KIND_LINE, 200, 1,
            mk_point(10*METRE-1, 0, 1, 1, 201));
    add_row(mk_seg(0, 0, 30*METRE, 0, 0, 0, 0, 0), KIND_LINE, 1000, 1,
            mk_point(30*METRE, 0, 1, 1, 1001));
    add_row(mk_seg(0, 0, 30*METRE-1, 0, 0, 0, 0, 0), KIND_LINE, 500, 1,
            mk_point(30*METRE-1, 0, 1, 1, 501));
    // coordinate extremes
    add_row(seg_wide, KIND_LINE,   0,    1, mk_point(COORD_MIN, COORD_MIN, 1, 0, 1001));
    add_row(seg_wide, KIND_LINE,   1000, 1, mk_point(COORD_MAX, COORD_MAX, 1, 1, 1001));
    add_row(seg_wide, KIND_LINE,   500,  0, '0);
    add_row(seg_knot, KIND_BEZIER, 333,  0, '0);
    add_row(seg_knot, KIND_BEZIER, 1001, 1, mk_point(0, 0, 0, 0, 1001));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // hand-picked requests under the reset values
    foreach (directed_rows[r]) begin
      send_segment(directed_rows[r].seg, directed_rows[r].kind, directed_rows[r].k,
                   directed_rows[r].typed, directed_rows[r].want);
      pace_sender();
    end

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      // registers change only with nothing in flight
      settle_block();
      setting = active_setting;
      case (phase)
        0: ;   // stay on the reset values
        1: setting = '{near_limit: '0, far_limit: '0,
                       near_count: '0, mid_count: '0, far_count: '0};
        2: setting = '{near_limit: LIMIT_MAX, far_limit: LIMIT_MAX,
                       near_count: COUNT_MAX, mid_count: COUNT_MAX, far_count: COUNT_MAX};
        3: begin
          // near limit above far limit
          setting.near_limit = LIMIT_BITS'(1) << 30;
          setting.far_limit  = LIMIT_BITS'(1) << 12;
          setting.near_count = COUNT_BITS'($urandom_range(1, 30));
          setting.mid_count  = COUNT_BITS'($urandom_range(1, 30));
          setting.far_count  = COUNT_BITS'($urandom_range(1, 30));
        end
        default: begin
          setting.near_limit = LIMIT_BITS'({$urandom, $urandom}) >> $urandom_range(0, 47);
          setting.far_limit  = LIMIT_BITS'({$urandom, $urandom}) >> $urandom_range(0, 47);
          // mostly short paths so indexes often reach the end
          setting.near_count = COUNT_BITS'(($urandom_range(0, 5) == 0) ?
                                           $urandom_range(0, 4095) : $urandom_range(0, 48));
          setting.mid_count  = COUNT_BITS'(($urandom_range(0, 5) == 0) ?
                                           $urandom_range(0, 4095) : $urandom_range(0, 48));
          setting.far_count  = COUNT_BITS'(($urandom_range(0, 5) == 0) ?
                                           $urandom_range(0, 4095) : $urandom_range(0, 48));
        end
      endcase
      if (phase != 0)
        load_setting(setting, phase == 1 || phase % 3 == 0);
      steady = (phase == 2 || phase == 5);

      for (int item = 0; item < ITEMS_PER_PHASE; item++) begin
        pick = $urandom_range(0, 19);
        kind = (pick == 0) ? KIND_FREE : (pick == 1) ? KIND_SPARE :
               (pick < 11) ? KIND_LINE : KIND_BEZIER;
        // finish and control points sit at a random scale from the start,
        // so segment lengths spread over all three bands
        s.sx  = coord_t'($urandom);
        s.sy  = coord_t'($urandom);
        sh    = $urandom_range(0, COORD_BITS-1);
        s.fx  = s.sx + (coord_t'($urandom) >>> sh);
        s.fy  = s.sy + (coord_t'($urandom) >>> sh);
        s.c1x = s.sx + (coord_t'($urandom) >>> $urandom_range(0, COORD_BITS-1));
        s.c1y = s.sy + (coord_t'($urandom) >>> $urandom_range(0, COORD_BITS-1));
        s.c2x = s.fx + (coord_t'($urandom) >>> $urandom_range(0, COORD_BITS-1));
        s.c2y = s.fy + (coord_t'($urandom) >>> $urandom_range(0, COORD_BITS-1));
        // most indexes land on the path, some on its ends or just past it
        n    = interval_count(s);
        pick = $urandom_range(0, 9);
        case (pick)
          0:       k = $urandom_range(0, 4095);
          1:       k = n;
          2:       k = (n < 4095) ? n + 1 : n;
          3:       k = 0;
          default: k = $urandom_range(0, n);
        endcase
        send_segment(s, kind, COUNT_BITS'(k), 1'b0, '0);
        // now and then hold off until the pipeline has emptied
        if ($urandom_range(0, 199) == 0)
          settle_block();
        else
          pace_sender();
      end
    end

    // final drain, bounded so a lost point is reported rather than hung on
    s_axis_tvalid <= 1'b0;
    waited = 0;
    while (expected_points.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (2 * PIPE_LATENCY) @(posedge clk_i);
    if (expected_points.size() != 0)
      report_mismatch("points never returned", 64'(expected_points.size()), 64'(0));

    $display("run covered %0d requests under %0d register settings", requests_sent,
             settings_used);
    $display("points checked %0d: %0d on the path, %0d past its end, %0d free, %0d mismatches",
             points_checked, points_in_range, points_beyond, points_free, mismatches);
    if (mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  // watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("TEST FAILED");
    $finish;
  end

endmodule

[filelist.f]
rtl/pps_pkg.sv
rtl/pps_lerp.sv
rtl/pps_count.sv
rtl/pps_div.sv
rtl/pps_bezier.sv
rtl/path_point_sampler.sv
verif/tb_top.sv
